[hw/rtl/kslist_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kslist_pkg
// Shared types and codes for the keyed sequential list: the operation codes,
// the entry layout and the commands that steer the chain of entry cells.
// ----------------------------------------------------------------------------
package kslist_pkg;

    // Operation codes carried in the func field of an input item.
    localparam int FUNC_W = 3;
    localparam logic [FUNC_W-1:0] FUNC_APPEND = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_UPDATE = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_GET    = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd6;

    localparam int KEY_W   = 32;
    localparam int VALUE_W = 64;

    // Commands broadcast to every cell of the chain.
    localparam int CELL_OP_W = 3;
    localparam logic [CELL_OP_W-1:0] CELL_HOLD   = 3'd0;
    localparam logic [CELL_OP_W-1:0] CELL_ROTATE = 3'd1;
    localparam logic [CELL_OP_W-1:0] CELL_CLOSE  = 3'd2;
    localparam logic [CELL_OP_W-1:0] CELL_OPEN   = 3'd3;
    localparam logic [CELL_OP_W-1:0] CELL_APPEND = 3'd4;

    // One list entry.
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } entry_t;

    // Command and write data sent down the chain.
    typedef struct packed {
        logic [CELL_OP_W-1:0] op;
        entry_t               new_entry;
    } cell_cmd_t;

    // Outcome of a scan through the head unit.
    typedef struct packed {
        logic   found;
        entry_t entry;
    } head_res_t;

endpackage : kslist_pkg
`default_nettype wire

[hw/rtl/keyed_sequential_list.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_sequential_list
// Ordered key/value list held in a chain of entry cells, with a head unit
// for searches and a single output register.
// ----------------------------------------------------------------------------
// The list lives in CAPACITY cells, one entry each, in list order. Append
// and insert at position act on all cells at once; clear only resets the
// count. Remove, update, get and read at position rotate the whole chain
// once past the head unit, one entry per cycle, and the rotation length,
// not the list fill, sets how long they take. One item is worked at a
// time; a finished result sits in the output register and the next item
// is taken while it waits. There is no clearing pass after reset: the
// store contents are undefined until written and only entries below the
// count are ever returned.
// ----------------------------------------------------------------------------
module keyed_sequential_list
    import kslist_pkg::*;
#(
    parameter int CAPACITY = 1024,
    localparam int CNT_W   = $clog2(CAPACITY + 1),
    localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire logic [FUNC_W-1:0]  func,
    input  wire logic signed [31:0] entry_key,
    input  wire logic [63:0]        entry_value,
    input  wire logic [CNT_W-1:0]   position,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output logic                    ok,
    output logic signed [31:0]      found_key,
    output logic [63:0]             found_value,
    output logic [CNT_W-1:0]        entry_count,
    output logic                    is_full,
    output logic                    is_empty
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_APPLY = 2'd2;

    localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [FUNC_W-1:0] op_func_reg;
    entry_t            op_entry_reg;
    logic [CNT_W-1:0]  op_pos_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    logic              out_valid_reg;
    logic              out_ok_reg;
    logic [31:0]       out_key_reg;
    logic [63:0]       out_value_reg;
    logic [CNT_W-1:0]  out_count_reg;

    logic              req_accept;
    logic              apply_fire;
    logic              res_ok;
    entry_t            res_entry;
    logic [CELL_OP_W-1:0] apply_op;
    cell_cmd_t         cmd;

    entry_t            cell_entry [CAPACITY];
    logic              cell_mark  [CAPACITY];
    entry_t            feed_entry;
    logic              feed_mark;
    logic              scan_last;
    head_res_t         head_res;

    assign req_stall  = (state_reg != ST_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign apply_fire = (state_reg == ST_APPLY) && (!out_valid_reg || !rsp_stall);

    // Head unit: search, capture and marking on the rotating stream.
    kslist_head #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W),
        .IDX_W    (IDX_W)
    ) u_head (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (req_accept),
        .step       (state_reg == ST_SCAN),
        .func       (op_func_reg),
        .op_entry   (op_entry_reg),
        .pos        (op_pos_reg),
        .count      (count_reg),
        .head_entry (cell_entry[0]),
        .feed_entry (feed_entry),
        .feed_mark  (feed_mark),
        .last       (scan_last),
        .res        (head_res)
    );

    // Chain of entry cells; the top cell is fed from the head unit.
    for (genvar gi = 0; gi < CAPACITY; gi++)
    begin : g_cell
        entry_t up_entry;
        logic   up_mark;
        entry_t down_entry;

        if (gi == CAPACITY - 1)
        begin : g_top
            assign up_entry = feed_entry;
            assign up_mark  = feed_mark;
        end
        else
        begin : g_mid
            assign up_entry = cell_entry[gi+1];
            assign up_mark  = cell_mark[gi+1];
        end

        if (gi == 0)
        begin : g_bottom
            assign down_entry = cmd.new_entry;
        end
        else
        begin : g_low
            assign down_entry = cell_entry[gi-1];
        end

        kslist_cell #(
            .INDEX (gi),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .pos        (op_pos_reg),
            .count      (count_reg),
            .up_entry   (up_entry),
            .up_mark    (up_mark),
            .down_entry (down_entry),
            .entry      (cell_entry[gi]),
            .mark       (cell_mark[gi])
        );
    end

    // Result and store change for the operation in hand.
    always_comb
    begin
        res_ok     = 1'b0;
        res_entry  = '0;
        apply_op   = CELL_HOLD;
        count_next = count_reg;
        case (op_func_reg)
            FUNC_APPEND:
            begin
                if (count_reg < CAP_COUNT)
                begin
                    apply_op   = CELL_APPEND;
                    count_next = count_reg + CNT_W'(1);
                    res_ok     = 1'b1;
                end
            end
            FUNC_REMOVE:
            begin
                apply_op = CELL_CLOSE;
                if (head_res.found)
                begin
                    count_next = count_reg - CNT_W'(1);
                    res_ok     = 1'b1;
                end
            end
            FUNC_UPDATE:
            begin
                res_ok = head_res.found;
            end
            FUNC_GET, FUNC_READ:
            begin
                res_ok = head_res.found;
                if (head_res.found)
                begin
                    res_entry = head_res.entry;
                end
            end
            FUNC_INSERT:
            begin
                if ((count_reg < CAP_COUNT) && (op_pos_reg <= count_reg))
                begin
                    apply_op   = CELL_OPEN;
                    count_next = count_reg + CNT_W'(1);
                    res_ok     = 1'b1;
                end
            end
            FUNC_CLEAR:
            begin
                count_next = '0;
                res_ok     = 1'b1;
            end
            default:
            begin
                res_ok = 1'b0;
            end
        endcase
    end

    // Command broadcast to the cells.
    always_comb
    begin
        cmd.new_entry = op_entry_reg;
        if (state_reg == ST_SCAN)
        begin
            cmd.op = CELL_ROTATE;
        end
        else if (apply_fire)
        begin
            cmd.op = apply_op;
        end
        else
        begin
            cmd.op = CELL_HOLD;
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    if (func inside {FUNC_REMOVE, FUNC_UPDATE, FUNC_GET, FUNC_READ})
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_APPLY;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                if (apply_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            op_func_reg   <= FUNC_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (req_accept)
            begin
                op_func_reg <= func;
            end
            if (apply_fire)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Operation operands and result payload.
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            op_entry_reg.key   <= $unsigned(entry_key);
            op_entry_reg.value <= entry_value;
            op_pos_reg         <= position;
        end
        if (apply_fire)
        begin
            out_ok_reg    <= res_ok;
            out_key_reg   <= res_entry.key;
            out_value_reg <= res_entry.value;
            out_count_reg <= count_next;
        end
    end

    assign rsp_valid   = out_valid_reg;
    assign ok          = out_ok_reg;
    assign found_key   = $signed(out_key_reg);
    assign found_value = out_value_reg;
    assign entry_count = out_count_reg;
    assign is_full     = (out_count_reg == CAP_COUNT);
    assign is_empty    = (out_count_reg == '0);

    // The count never passes the capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_COUNT)
        else $error("entry count above capacity");

    // An accepted item always leaves the idle state.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_accept |=> (state_reg != ST_IDLE))
        else $error("accepted item did not start");

    // The last scan step hands over to the apply step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && scan_last) |=> (state_reg == ST_APPLY))
        else $error("scan did not end after a full rotation");

    // Apart from clear, the count moves by at most one per item.
    assert property (@(posedge clk) disable iff (!rst_n)
        (apply_fire && op_func_reg != FUNC_CLEAR) |=>
            (count_reg == $past(count_reg)) ||
            (count_reg == $past(count_reg) + CNT_W'(1)) ||
            (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("count moved by more than one");

    // A new result is only loaded when the output register is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        apply_fire |-> (!out_valid_reg || !rsp_stall))
        else $error("result overwrote a pending result");

endmodule : keyed_sequential_list
`default_nettype wire

[hw/rtl/kslist_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kslist_cell
// One slot of the list. It holds an entry and a mark bit, and on each
// command either keeps them, takes them from its upper neighbor (rotation),
// takes the entry of its upper neighbor (gap closing) or of its lower
// neighbor (gap opening), or writes the new entry at its own position.
// ----------------------------------------------------------------------------
module kslist_cell
    import kslist_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int CNT_W = 11
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cell_cmd_t        cmd,
    input  wire logic [CNT_W-1:0] pos,
    input  wire logic [CNT_W-1:0] count,
    input  wire entry_t           up_entry,
    input  wire logic             up_mark,
    input  wire entry_t           down_entry,
    output entry_t                entry,
    output logic                  mark
);

    localparam logic [CNT_W-1:0] MY_INDEX = CNT_W'(INDEX);

    entry_t entry_reg;
    entry_t entry_next;
    logic   mark_reg;
    logic   mark_next;

    // Select the next contents from the broadcast command.
    always_comb
    begin
        entry_next = entry_reg;
        mark_next  = mark_reg;
        case (cmd.op)
            CELL_ROTATE:
            begin
                entry_next = up_entry;
                mark_next  = up_mark;
            end
            CELL_CLOSE:
            begin
                if (mark_reg)
                begin
                    entry_next = up_entry;
                end
                mark_next = 1'b0;
            end
            CELL_OPEN:
            begin
                if (MY_INDEX > pos)
                begin
                    entry_next = down_entry;
                end
                else if (MY_INDEX == pos)
                begin
                    entry_next = cmd.new_entry;
                end
            end
            CELL_APPEND:
            begin
                if (MY_INDEX == count)
                begin
                    entry_next = cmd.new_entry;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    // The mark bit is control state and is cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_reg <= 1'b0;
        end
        else
        begin
            mark_reg <= mark_next;
        end
    end

    // Entry payload.
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign mark  = mark_reg;

endmodule : kslist_cell
`default_nettype wire

[hw/rtl/kslist_head.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kslist_head
// Head unit of the rotating chain. During a scan it sees one entry per
// cycle in list order at cell 0, finds the first key match or the requested
// position, captures that entry, rewrites the value for an update and marks
// the entries from a removed one onward before feeding them back to the
// top of the chain.
// ----------------------------------------------------------------------------
module kslist_head
    import kslist_pkg::*;
#(
    parameter int CAPACITY = 1024,
    parameter int CNT_W    = 11,
    parameter int IDX_W    = 10
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              step,
    input  wire logic [FUNC_W-1:0] func,
    input  wire entry_t            op_entry,
    input  wire logic [CNT_W-1:0]  pos,
    input  wire logic [CNT_W-1:0]  count,
    input  wire entry_t            head_entry,
    output entry_t                 feed_entry,
    output logic                   feed_mark,
    output logic                   last,
    output head_res_t              res
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             found_reg;
    logic             found_next;
    entry_t           cap_reg;
    logic             in_list;
    logic             key_op;
    logic             key_hit;
    logic             pos_hit;

    // Compare the entry now at the head against the operation.
    always_comb
    begin
        in_list = CNT_W'(idx_reg) < count;
        key_op  = (func == FUNC_REMOVE) || (func == FUNC_UPDATE) || (func == FUNC_GET);
        key_hit = key_op && in_list && !found_reg && (head_entry.key == op_entry.key);
        pos_hit = (func == FUNC_READ) && in_list && !found_reg && (CNT_W'(idx_reg) == pos);
    end

    // Build the entry fed back into the top of the chain.
    always_comb
    begin
        feed_entry = head_entry;
        if ((func == FUNC_UPDATE) && key_hit)
        begin
            feed_entry.value = op_entry.value;
        end
        feed_mark = (func == FUNC_REMOVE) && (found_reg || key_hit);
    end

    // Scan position and search flag.
    always_comb
    begin
        idx_next   = idx_reg;
        found_next = found_reg;
        if (start)
        begin
            idx_next   = '0;
            found_next = 1'b0;
        end
        else if (step)
        begin
            idx_next   = last ? '0 : idx_reg + IDX_W'(1);
            found_next = found_reg || key_hit || pos_hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            found_reg <= found_next;
        end
    end

    // Capture the first matching entry.
    always_ff @(posedge clk)
    begin
        if (step && (key_hit || pos_hit))
        begin
            cap_reg <= head_entry;
        end
    end

    assign last      = (idx_reg == LAST_IDX);
    assign res.found = found_reg;
    assign res.entry = cap_reg;

endmodule : kslist_head
`default_nettype wire

[tb/keyed_sequential_list_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_sequential_list_tb
// Drives list operations into the keyed sequential list and checks every
// result against a behavioral list model. Directed tests cover the empty
// list, the edge keys and values, duplicates and out-of-range positions.
// Random phases then mix all operations under varying idle and stall levels.
// ----------------------------------------------------------------------------
module keyed_sequential_list_tb;
    import kslist_pkg::*;

    localparam int CAP   = 1024;
    localparam int CNT_W = $clog2(CAP + 1);

    // The one operation code that the block leaves undefined.
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 3'd7;

    typedef struct packed {
        logic               ok;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        logic [CNT_W-1:0]   count;
        logic               full;
        logic               empty;
    } list_result_t;

    logic                      clk         = 1'b0;
    logic                      rst_n       = 1'b0;
    logic                      req_valid   = 1'b0;
    logic                      req_stall;
    logic [FUNC_W-1:0]         func        = FUNC_CLEAR;
    logic signed [KEY_W-1:0]   entry_key   = '0;
    logic [VALUE_W-1:0]        entry_value = '0;
    logic [CNT_W-1:0]          position    = '0;
    logic                      rsp_valid;
    logic                      rsp_stall   = 1'b0;
    logic                      ok;
    logic signed [KEY_W-1:0]   found_key;
    logic [VALUE_W-1:0]        found_value;
    logic [CNT_W-1:0]          entry_count;
    logic                      is_full;
    logic                      is_empty;

    // Shadow copy of the list contents.
    logic [KEY_W-1:0]   shadow_keys [CAP];
    logic [VALUE_W-1:0] shadow_values [CAP];
    int                 shadow_count = 0;

    list_result_t pending_results[$];
    int unsigned  error_count = 0;
    int unsigned  idle_pct    = 0;
    int unsigned  stall_pct   = 0;

    keyed_sequential_list #(.CAPACITY(CAP)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .func        (func),
        .entry_key   (entry_key),
        .entry_value (entry_value),
        .position    (position),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .ok          (ok),
        .found_key   (found_key),
        .found_value (found_value),
        .entry_count (entry_count),
        .is_full     (is_full),
        .is_empty    (is_empty)
    );

    always #2 clk = ~clk;

    // Position of the first entry holding the key, or -1 when it is absent.
    function automatic int find_shadow_key(logic [KEY_W-1:0] key);
        for (int i = 0; i < shadow_count; i++)
        begin
            if (shadow_keys[i] == key)
                return i;
        end
        return -1;
    endfunction

    // Applies one operation to the shadow list and returns the result it gives.
    function automatic list_result_t apply_list_op(logic [FUNC_W-1:0] op,
                                                   logic [KEY_W-1:0] key,
                                                   logic [VALUE_W-1:0] value,
                                                   logic [CNT_W-1:0] pos);
        list_result_t res;
        int           hit;
        res = '0;
        case (op)
            FUNC_APPEND:
            begin
                if (shadow_count < CAP)
                begin
                    shadow_keys[shadow_count]   = key;
                    shadow_values[shadow_count] = value;
                    shadow_count++;
                    res.ok = 1'b1;
                end
            end
            FUNC_REMOVE:
            begin
                hit = find_shadow_key(key);
                if (hit >= 0)
                begin
                    for (int i = hit; i + 1 < shadow_count; i++)
                    begin
                        shadow_keys[i]   = shadow_keys[i + 1];
                        shadow_values[i] = shadow_values[i + 1];
                    end
                    shadow_count--;
                    res.ok = 1'b1;
                end
            end
            FUNC_UPDATE:
            begin
                hit = find_shadow_key(key);
                if (hit >= 0)
                begin
                    shadow_values[hit] = value;
                    res.ok = 1'b1;
                end
            end
            FUNC_GET:
            begin
                hit = find_shadow_key(key);
                if (hit >= 0)
                begin
                    res.key   = shadow_keys[hit];
                    res.value = shadow_values[hit];
                    res.ok    = 1'b1;
                end
            end
            FUNC_READ:
            begin
                if (pos < shadow_count)
                begin
                    res.key   = shadow_keys[pos];
                    res.value = shadow_values[pos];
                    res.ok    = 1'b1;
                end
            end
            FUNC_INSERT:
            begin
                if (shadow_count < CAP && pos <= shadow_count)
                begin
                    for (int i = shadow_count; i > pos; i--)
                    begin
                        shadow_keys[i]   = shadow_keys[i - 1];
                        shadow_values[i] = shadow_values[i - 1];
                    end
                    shadow_keys[pos]   = key;
                    shadow_values[pos] = value;
                    shadow_count++;
                    res.ok = 1'b1;
                end
            end
            FUNC_CLEAR:
            begin
                shadow_count = 0;
                res.ok = 1'b1;
            end
            default:
            begin
            end
        endcase
        res.count = shadow_count[CNT_W-1:0];
        res.full  = (shadow_count == CAP);
        res.empty = (shadow_count == 0);
        return res;
    endfunction

    // Presents one item, waits until the block takes it, then records the
    // result that it must produce. Valid stays high into the next item
    // unless an idle gap is drawn.
    task automatic send_op(input logic [FUNC_W-1:0] op, input logic [KEY_W-1:0] key,
                           input logic [VALUE_W-1:0] value, input int unsigned pos);
        if ($urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        req_valid   <= 1'b1;
        func        <= op;
        entry_key   <= key;
        entry_value <= value;
        position    <= pos[CNT_W-1:0];
        do
            @(posedge clk);
        while (req_stall);
        pending_results.push_back(apply_list_op(op, key, value, pos[CNT_W-1:0]));
    endtask

    task automatic set_idling(input int unsigned sender_pct, input int unsigned recv_pct);
        idle_pct = sender_pct;
        stall_pct <= recv_pct;
    endtask

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("%s", msg);
    endtask

    // Receiver: random stall, and each accepted result is checked against
    // the oldest pending one.
    always @(posedge clk)
    begin
        list_result_t want;
        rsp_stall <= ($urandom_range(99) < stall_pct);
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_results.size() == 0)
            begin
                report_error($sformatf("unexpected result ok=%0d key=%h value=%h count=%0d",
                                       ok, found_key, found_value, entry_count));
            end
            else
            begin
                want = pending_results.pop_front();
                if (ok !== want.ok || found_key !== want.key ||
                    found_value !== want.value || entry_count !== want.count ||
                    is_full !== want.full || is_empty !== want.empty)
                begin
                    report_error($sformatf({"result mismatch: expected ok=%0d key=%h ",
                        "value=%h count=%0d full=%0d empty=%0d, got ok=%0d key=%h ",
                        "value=%h count=%0d full=%0d empty=%0d"},
                        want.ok, want.key, want.value, want.count, want.full, want.empty,
                        ok, found_key, found_value, entry_count, is_full, is_empty));
                end
            end
        end
    end

    // Every key and position operation on an empty list must miss.
    task automatic test_empty_list();
        send_op(FUNC_GET, 32'h0000_0000, '0, 0);
        send_op(FUNC_REMOVE, 32'h8000_0000, '0, 0);
        send_op(FUNC_UPDATE, 32'hFFFF_FFFF, '1, 0);
        send_op(FUNC_READ, 32'h0000_0000, '0, 0);
        send_op(FUNC_INSERT, 32'h1234_5678, 64'h1, 1);
        send_op(FUNC_UNUSED, 32'h7FFF_FFFF, '1, CAP);
        send_op(FUNC_CLEAR, 32'h0000_0000, '0, 0);
    endtask

    // Edge keys and values, inserts at the front, middle and end, duplicate
    // keys, out-of-range positions and clear.
    task automatic test_basic_ops();
        send_op(FUNC_APPEND, 32'h8000_0000, 64'h0, 0);
        send_op(FUNC_APPEND, 32'h7FFF_FFFF, '1, 0);
        send_op(FUNC_INSERT, 32'h0000_0000, 64'h0000_0000_0000_0005, 0);
        send_op(FUNC_INSERT, 32'hFFFF_FFFF, 64'h0123_4567_89AB_CDEF, 3);
        send_op(FUNC_INSERT, 32'h7FFF_FFFF, 64'hFEDC_BA98_7654_3210, 2);
        send_op(FUNC_GET, 32'h7FFF_FFFF, '0, 0);
        send_op(FUNC_UPDATE, 32'h7FFF_FFFF, 64'h8000_0000_0000_0001, 0);
        send_op(FUNC_READ, '0, '0, 0);
        send_op(FUNC_READ, '0, '0, 4);
        send_op(FUNC_READ, '0, '0, 5);
        send_op(FUNC_READ, '0, '0, CAP);
        send_op(FUNC_REMOVE, 32'h7FFF_FFFF, '0, 0);
        send_op(FUNC_GET, 32'h7FFF_FFFF, '0, 0);
        send_op(FUNC_REMOVE, 32'hFFFF_FFFF, '0, 0);
        send_op(FUNC_INSERT, 32'h5555_AAAA, '1, 10);
        send_op(FUNC_CLEAR, '0, '0, 0);
    endtask

    // One random operation. Keys mostly come from the list itself so that
    // key operations hit; small keys make duplicates common.
    task automatic send_random_op();
        int unsigned        roll;
        logic [FUNC_W-1:0]  op;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        int unsigned        pos;
        roll = $urandom_range(99);
        if (roll < 34)
            op = FUNC_APPEND;
        else if (roll < 48)
            op = FUNC_INSERT;
        else if (roll < 60)
            op = FUNC_REMOVE;
        else if (roll < 71)
            op = FUNC_UPDATE;
        else if (roll < 83)
            op = FUNC_GET;
        else if (roll < 95)
            op = FUNC_READ;
        else if (roll < 98)
            op = FUNC_CLEAR;
        else
            op = FUNC_UNUSED;

        if (shadow_count > 0 && $urandom_range(99) < 70)
            key = shadow_keys[$urandom_range(shadow_count - 1)];
        else
        begin
            case ($urandom_range(3))
                0: key = 32'h8000_0000;
                1: key = 32'h7FFF_FFFF;
                2: key = $urandom_range(7);
                default: key = $urandom;
            endcase
        end

        case ($urandom_range(7))
            0: value = '0;
            1: value = '1;
            default: value = {$urandom, $urandom};
        endcase

        if (op == FUNC_INSERT && $urandom_range(99) < 85)
            pos = $urandom_range(shadow_count);
        else if (op == FUNC_READ && shadow_count > 0 && $urandom_range(99) < 85)
            pos = $urandom_range(shadow_count - 1);
        else
            pos = $urandom_range(CAP);

        send_op(op, key, value, pos);
    endtask

    task automatic test_random_ops();
        set_idling(0, 0);
        repeat (139) send_random_op();
        set_idling(82, 0);
        repeat (139) send_random_op();
        set_idling(0, 82);
        repeat (139) send_random_op();
        set_idling(29, 29);
        repeat (139) send_random_op();
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idling(0, 0);
        test_empty_list();
        test_basic_ops();
        test_random_ops();
        req_valid <= 1'b0;

        // Drain, then leave room for any stray result.
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (CAP + 8) @(posedge clk);

        if (error_count == 0 && pending_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial
    begin
        #40_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
